/* src/adsr_env_pkg.sv */
// Shared constants, phase codes and transaction types for the ADSR envelope generator.
package adsr_env_pkg;

  // Fixed-point format of the level: 13 integer bits over FRAC_BITS fraction bits.
  localparam int FRAC_BITS = 16;
  localparam int LEVEL_W   = 13 + FRAC_BITS;
  localparam int TARGET_W  = 13;
  localparam int SUSTAIN_W = 12;
  localparam int OUT_LVL_W = 12;
  localparam int PHASE_W   = 3;

  // Per-tick decay factor of 65470/65536, applied as multiply then shift.
  localparam int COEF_W     = 16;
  localparam int COEF_SHIFT = 16;
  localparam logic [COEF_W-1:0] COEF_NUM = 16'd65470;

  // Level thresholds in fixed point.
  localparam logic [LEVEL_W-1:0] LEVEL_ONE  = LEVEL_W'(1) << FRAC_BITS;
  localparam logic [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(4096) << FRAC_BITS;
  localparam logic [LEVEL_W-1:0] LEVEL_PEAK = LEVEL_W'(4095) << FRAC_BITS;
  localparam logic [LEVEL_W-1:0] LEVEL_SNAP = LEVEL_W'(3) << (FRAC_BITS - 1);

  // Reset value of the attack target register.
  localparam logic [TARGET_W-1:0] TARGET_RESET = 13'd4915;

  // Envelope phase codes.
  localparam logic [PHASE_W-1:0] PH_OFF     = 3'd0;
  localparam logic [PHASE_W-1:0] PH_ATTACK  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_DECAY   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_SUSTAIN = 3'd3;
  localparam logic [PHASE_W-1:0] PH_RELEASE = 3'd4;

  // Input transaction: one control tick.
  typedef struct packed {
    logic                 gate;
    logic [SUSTAIN_W-1:0] sustain_level;
  } adsr_in_t;

  // Result transaction: level and phase after the tick.
  typedef struct packed {
    logic [OUT_LVL_W-1:0] level;
    logic [PHASE_W-1:0]   phase;
  } adsr_out_t;

endpackage

/* src/adsr_env_step.sv */
// Next-state logic of the envelope: one tick of phase and level update.
module adsr_env_step
  import adsr_env_pkg::*;
(
  input  logic [PHASE_W-1:0]  phase,
  input  logic [LEVEL_W-1:0]  level,
  input  adsr_in_t            tick,
  input  logic [TARGET_W-1:0] attack_target,
  output logic [PHASE_W-1:0]  phase_next,
  output logic [LEVEL_W-1:0]  level_next
);

  logic [LEVEL_W-1:0]        sus;
  logic [LEVEL_W-1:0]        tgt;
  logic                      above_tgt;
  logic                      above_sus;
  logic [LEVEL_W-1:0]        dist_tgt;
  logic [LEVEL_W-1:0]        mul_in;
  logic [LEVEL_W+COEF_W-1:0] product;
  logic [LEVEL_W-1:0]        scaled;
  logic [LEVEL_W-1:0]        lvl_attack;
  logic [LEVEL_W-1:0]        lvl_decay;

  // Sustain level and attack target in fixed point.
  assign sus = LEVEL_W'(tick.sustain_level) << FRAC_BITS;
  assign tgt = LEVEL_W'(attack_target) << FRAC_BITS;

  // Distances to the attack target and the sustain level.
  assign above_tgt = (level >= tgt);
  assign above_sus = (level > sus);
  assign dist_tgt  = above_tgt ? (level - tgt) : (tgt - level);

  // One shared multiplier: the operand depends on which phase scales this tick.
  always_comb begin
    if (!tick.gate) begin
      mul_in = level;
    end else if (phase == PH_ATTACK) begin
      mul_in = dist_tgt;
    end else begin
      mul_in = level - sus;
    end
  end

  assign product = (LEVEL_W + COEF_W)'(mul_in) * (LEVEL_W + COEF_W)'(COEF_NUM);
  assign scaled  = product[COEF_SHIFT +: LEVEL_W];

  // Attack moves toward the target from either side; decay only from above.
  assign lvl_attack = above_tgt ? (tgt + scaled) : (tgt - scaled);
  assign lvl_decay  = above_sus ? (sus + scaled) : level;

  // Phase transitions and level update.
  always_comb begin
    phase_next = phase;
    level_next = level;
    if (tick.gate) begin
      unique case (phase)
        PH_ATTACK: begin
          if (lvl_attack >= LEVEL_FULL) begin
            level_next = LEVEL_PEAK;
            phase_next = PH_DECAY;
          end else begin
            level_next = lvl_attack;
          end
        end
        PH_DECAY: begin
          if (lvl_decay <= sus + LEVEL_SNAP) begin
            level_next = sus;
            phase_next = PH_SUSTAIN;
          end else begin
            level_next = lvl_decay;
          end
        end
        PH_SUSTAIN: begin
          level_next = sus;
        end
        default: begin
          // Off, release and unused codes restart the attack.
          phase_next = PH_ATTACK;
        end
      endcase
    end else if (level != '0) begin
      phase_next = PH_RELEASE;
      level_next = (level > LEVEL_ONE) ? scaled : '0;
    end else begin
      phase_next = PH_OFF;
    end
  end

endmodule

/* src/adsr_envelope_generator_unit.sv */
// Top level of the ADSR envelope generator: handshake, state and result registers.
//
// Single-channel ADSR envelope generator. Each input transaction is one control tick
// carrying the gate bit and a 12-bit sustain level; each tick yields exactly one result
// transaction with the integer part of the new level and the new phase (0 off, 1 attack,
// 2 decay, 3 sustain, 4 release). The level is kept in unsigned fixed point with 13
// integer and 16 fraction bits and moves by a factor of 65470/65536 per tick. A tick
// is registered on entry, updated by one pass through the next-state logic (a single
// shared 29x16 multiplier plus adds and compares), and its result then moves to the
// output register when it is free or drained; a new tick is taken every cycle while the
// output side keeps up. The attack target register resets to 4915; the user writes it
// through the configuration channel only with no tick in flight, unenforced by the block.
module adsr_envelope_generator_unit
  import adsr_env_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  adsr_in_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output adsr_out_t           out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [TARGET_W-1:0] cfg_data
);

  logic [TARGET_W-1:0] attack_target;
  logic [PHASE_W-1:0]  phase;
  logic [LEVEL_W-1:0]  level;
  logic [PHASE_W-1:0]  phase_next;
  logic [LEVEL_W-1:0]  level_next;
  logic                tick_valid;
  adsr_in_t            tick;
  logic                advance;

  // The configuration register takes a write on any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_target <= TARGET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      attack_target <= cfg_data;
    end
  end

  // The input register moves on whenever the output register is free or drained.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = tick_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      tick_valid <= 1'b1;
    end else if (advance) begin
      tick_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      tick <= in_data;
    end
  end

  adsr_env_step u_step (
    .phase         (phase),
    .level         (level),
    .tick          (tick),
    .attack_target (attack_target),
    .phase_next    (phase_next),
    .level_next    (level_next)
  );

  // Envelope state and the result register update together when a tick is consumed.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_OFF;
      level     <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= tick_valid;
      if (tick_valid) begin
        phase <= phase_next;
        level <= level_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && tick_valid) begin
      out_data.level <= level_next[FRAC_BITS +: OUT_LVL_W];
      out_data.phase <= phase_next;
    end
  end

endmodule

/* test/adsr_envelope_generator_unit_check.sv */
// Envelope predictor and result comparison for the ADSR envelope generator testbench.
module adsr_envelope_generator_unit_check
  import adsr_env_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  adsr_in_t            in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  adsr_out_t           out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [TARGET_W-1:0] cfg_data,
  output int                  errors,
  output int                  pending
);

  // Predicted envelope state, held wider than the block so nothing wraps early.
  logic [TARGET_W-1:0] attack_goal;
  logic [PHASE_W-1:0]  env_phase;
  logic [63:0]         env_level;
  adsr_out_t           envelope_due[$];

  // One tick of the 65470/65536 factor on an unsigned distance, truncated.
  function automatic logic [63:0] damp(input logic [63:0] x);
    return (x * 64'(COEF_NUM)) >> COEF_SHIFT;
  endfunction

  // Advance the envelope by one tick and return the level and phase it shows.
  function automatic adsr_out_t step_envelope(input adsr_in_t tick);
    logic [63:0] sus;
    logic [63:0] goal;
    adsr_out_t   res;
    sus  = 64'(tick.sustain_level) << FRAC_BITS;
    goal = 64'(attack_goal) << FRAC_BITS;
    if (tick.gate) begin
      case (env_phase)
        PH_ATTACK: begin
          if (env_level >= goal) env_level = goal + damp(env_level - goal);
          else env_level = goal - damp(goal - env_level);
          if (env_level >= 64'(LEVEL_FULL)) begin
            env_level = 64'(LEVEL_PEAK);
            env_phase = PH_DECAY;
          end
        end
        PH_DECAY: begin
          if (env_level > sus) env_level = sus + damp(env_level - sus);
          if (env_level <= sus + 64'(LEVEL_SNAP)) begin
            env_level = sus;
            env_phase = PH_SUSTAIN;
          end
        end
        PH_SUSTAIN: begin
          env_level = sus;
        end
        default: begin
          env_phase = PH_ATTACK;
        end
      endcase
    end else if (env_level != 0) begin
      env_phase = PH_RELEASE;
      env_level = (env_level > 64'(LEVEL_ONE)) ? damp(env_level) : 64'd0;
    end else begin
      env_phase = PH_OFF;
    end
    env_level = env_level & ((64'd1 << LEVEL_W) - 64'd1);
    res.level = env_level[FRAC_BITS +: OUT_LVL_W];
    res.phase = env_phase;
    return res;
  endfunction

  // Follow every transaction at the clock edge: results are checked before new ticks queue.
  always @(posedge clk) begin
    adsr_out_t want;
    if (rst) begin
      attack_goal = TARGET_RESET;
      env_phase   = PH_OFF;
      env_level   = '0;
      errors      = 0;
      envelope_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) attack_goal = cfg_data;
      if (out_valid && !out_stall) begin
        if (envelope_due.size() == 0) begin
          $error("unexpected result: level %0d, phase %0d", out_data.level, out_data.phase);
          errors = errors + 1;
        end else begin
          want = envelope_due.pop_front();
          if (out_data.level !== want.level) begin
            $error("level: expected %0d, actual %0d", want.level, out_data.level);
            errors = errors + 1;
          end
          if (out_data.phase !== want.phase) begin
            $error("phase: expected %0d, actual %0d", want.phase, out_data.phase);
            errors = errors + 1;
          end
        end
      end
      if (in_valid && !in_stall) envelope_due.push_back(step_envelope(in_data));
    end
    pending <= envelope_due.size();
  end

endmodule

/* test/adsr_envelope_generator_unit_test.sv */
// Stimulus, clocking and verdict for the ADSR envelope generator testbench.
module adsr_envelope_generator_unit_test
  import adsr_env_pkg::*;
();

  localparam int STALL_LIMIT = 3000;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  adsr_in_t            in_data;
  logic                out_valid;
  logic                out_stall;
  adsr_out_t           out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [TARGET_W-1:0] cfg_data;
  int                  errors;
  int                  pending;

  // Shared pacing: quiet stretches run both sides without idle cycles.
  bit quiet;
  int ticks_sent;
  int results_taken;

  adsr_envelope_generator_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  adsr_envelope_generator_unit_check envelope_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one tick after a random gap and hold it until the transaction completes.
  task automatic send_tick(input logic gate, input logic [SUSTAIN_W-1:0] sustain);
    int       gap;
    adsr_in_t tick;
    gap = quiet ? 0 : $urandom_range(0, 9);
    tick.gate = gate;
    tick.sustain_level = sustain;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= tick;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ticks_sent++;
    if (ticks_sent % 97 == 0) quiet = ($urandom_range(0, 3) == 0);
  endtask

  // Stop offering ticks and wait until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the attack target while the block is idle.
  task automatic write_target(input logic [TARGET_W-1:0] goal);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= goal;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Note sequences: a gate-on run that mostly holds a high sustain level so decay
  // can settle, then a gate-off run. Some runs end on a near-zero sustain so the
  // release reaches zero and the envelope turns off.
  task automatic play_notes(input int count, input bit long_first);
    int                   played;
    int                   on_len;
    int                   off_len;
    int                   k;
    logic [SUSTAIN_W-1:0] sustain;
    played = 0;
    while (played < count) begin
      if (long_first) on_len = 760;
      else if ($urandom_range(0, 4) == 0) on_len = $urandom_range(1, 5);
      else on_len = $urandom_range(20, 90);
      long_first = 1'b0;
      for (k = 0; k < on_len; k++) begin
        if ($urandom_range(0, 7) == 0) sustain = SUSTAIN_W'($urandom);
        else sustain = SUSTAIN_W'($urandom_range(4085, 4095));
        if (k == on_len - 1 && $urandom_range(0, 9) == 0)
          sustain = SUSTAIN_W'($urandom_range(0, 1));
        send_tick(1'b1, sustain);
      end
      if ($urandom_range(0, 5) == 0) off_len = $urandom_range(30, 120);
      else off_len = $urandom_range(1, 12);
      for (k = 0; k < off_len; k++) send_tick(1'b0, SUSTAIN_W'($urandom));
      played += on_len + off_len;
    end
  endtask

  // Result side: random stall per transaction, with one long hold-off to back up the block.
  initial begin
    int hold;
    out_stall = 1'b1;
    forever begin
      if (results_taken == 400) hold = 300;
      else hold = quiet ? 0 : $urandom_range(0, 9);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_taken++;
    end
  end

  // Watchdog: too many cycles without any transaction ends the run.
  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("adsr_envelope_generator_unit: mismatch");
    $finish;
  end

  // Main sequence: reset, directed ticks, then note sequences under several targets.
  initial begin
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    quiet     = 1'b0;
    rst       = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset target: idle off, start of attack, release and retrigger.
    send_tick(1'b0, 12'h000);
    send_tick(1'b1, 12'hFFF);
    send_tick(1'b1, 12'h000);
    send_tick(1'b1, 12'hFFF);
    send_tick(1'b1, 12'h000);
    send_tick(1'b0, 12'hAAA);
    send_tick(1'b0, 12'h555);
    send_tick(1'b1, 12'h555);
    send_tick(1'b1, 12'hAAA);

    // Target of zero: attack approaches from above and never finishes.
    write_target('0);
    repeat (4) send_tick(1'b1, SUSTAIN_W'($urandom));
    send_tick(1'b0, 12'hFFF);
    send_tick(1'b0, 12'h000);

    // Target exactly at full scale: attack from below stalls short of decay.
    write_target(TARGET_W'(4096));
    repeat (3) send_tick(1'b1, SUSTAIN_W'($urandom));

    // Largest target, then random notes that reach decay, sustain and release.
    write_target({TARGET_W{1'b1}});
    repeat (3) send_tick(1'b1, 12'hFFF);
    play_notes(1000, 1'b1);

    write_target(TARGET_W'($urandom_range(4097, 8191)));
    play_notes(300, 1'b0);

    write_target(TARGET_W'($urandom_range(0, 8191)));
    play_notes(300, 1'b0);

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("adsr_envelope_generator_unit: match");
    end else begin
      $display("adsr_envelope_generator_unit: mismatch");
    end
    $finish;
  end

endmodule
